// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the bounded array list RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BAL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BAL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bal_pkg.sv -----
// Package for the bounded array list: item structs, codes and shared constants.
// No dependencies; used by every module of the block.
package bal_pkg;

    // Field widths of the request, response and capacity register.
    localparam int ACTION_BITS     = 3;
    localparam int INDEX_BITS      = 6;
    localparam int VALUE_BITS      = 8;
    localparam int STATUS_BITS     = 2;
    localparam int COUNT_BITS      = 7;
    localparam int CAPACITY_BITS   = 7;

    // Defaults for the top-level parameters.
    localparam int DEPTH_DEFAULT      = 64;
    localparam int ENTRY_BITS_DEFAULT = 8;

    // Capacity register value after reset.
    localparam logic [CAPACITY_BITS-1:0] CAPACITY_RESET = 7'd64;

    // Action codes.
    localparam logic [ACTION_BITS-1:0] ACT_APPEND   = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_INSERT   = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_REMOVE   = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_TRUNCATE = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_READ     = 3'd4;

    // Status codes.
    localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [ACTION_BITS-1:0] action;
        logic [INDEX_BITS-1:0]  index;
        logic [VALUE_BITS-1:0]  value;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [VALUE_BITS-1:0]  read_value;
        logic [COUNT_BITS-1:0]  count;
    } rsp_item_t;

    // Operation broadcast to every cell of the row.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [INDEX_BITS-1:0]  idx;
        logic [VALUE_BITS-1:0]  value;
        logic [INDEX_BITS-1:0]  rd_idx;
    } cell_cmd_t;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    // Number of registered radix-8 levels in the read tree.
    function automatic int tree_levels(int depth);
        int lv;
        lv = ($clog2(depth) + 2) / 3;
        return (lv < 1) ? 1 : lv;
    endfunction

endpackage

// ----- rtl/bounded_array_list_core.sv -----
// Bounded array list: a row of DEPTH cells shifts all entries in parallel.
// Append, insert, remove, truncate and no-op register their response at the
// accepting edge; a new request is taken every cycle while the output is free.
// A read goes through a registered radix-8 OR tree of ceil(log2(DEPTH)/3)
// levels (2 at DEPTH 64); no request is taken until its response is registered.
// Reset (rst_n, async, active low) clears length, capacity (to 64) and control.
`include "assert_macros.svh"

module bounded_array_list_core #(
    parameter int DEPTH      = bal_pkg::DEPTH_DEFAULT,
    parameter int ENTRY_BITS = bal_pkg::ENTRY_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  bal_pkg::req_item_t                  req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output bal_pkg::rsp_item_t                  rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bal_pkg::CAPACITY_BITS-1:0]   cfg_capacity
);
    import bal_pkg::*;

    localparam int LEN_W  = $clog2(DEPTH+1);
    localparam int LEVELS = tree_levels(DEPTH);
    localparam int WAIT_W = $clog2(LEVELS+1);
    localparam int CMP_W  = (LEN_W > CAPACITY_BITS) ? LEN_W : CAPACITY_BITS;
    localparam int IDXC_W = (LEN_W > INDEX_BITS) ? LEN_W : INDEX_BITS;

    state_t                   state_reg;
    state_t                   state_next;
    logic [LEN_W-1:0]         len_reg;
    logic [LEN_W-1:0]         len_next;
    logic [CAPACITY_BITS-1:0] capacity_reg;
    logic [WAIT_W-1:0]        wait_reg;
    logic [WAIT_W-1:0]        wait_next;
    logic [INDEX_BITS-1:0]    rd_idx_reg;
    logic [INDEX_BITS-1:0]    rd_idx_next;
    logic [STATUS_BITS-1:0]   rd_status_reg;
    logic [STATUS_BITS-1:0]   rd_status_next;
    rsp_item_t                rsp_reg;
    rsp_item_t                rsp_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;

    cell_cmd_t                cmd;
    logic                     accept;
    logic                     out_free;
    logic                     full;
    logic                     idx_gt_len;
    logic                     idx_ge_len;
    logic [STATUS_BITS-1:0]   status;
    logic [ENTRY_BITS-1:0]    cell_data [DEPTH];
    logic [ENTRY_BITS-1:0]    cell_leaf [DEPTH];
    logic [ENTRY_BITS-1:0]    tree_sum;

    // Handshake: a request transfer needs an idle controller and a free output.
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Full and range checks against the current length.
    always_comb
    begin
        full       = (CMP_W'(len_reg) >= CMP_W'(capacity_reg)) ||
                     (len_reg == LEN_W'(DEPTH));
        idx_gt_len = IDXC_W'(req.index) > IDXC_W'(len_reg);
        idx_ge_len = IDXC_W'(req.index) >= IDXC_W'(len_reg);
    end

    // Controller: decide the action, drive the cell row, build the response.
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        wait_next      = wait_reg;
        rd_idx_next    = rd_idx_reg;
        rd_status_next = rd_status_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        status         = ST_DONE;
        cmd.op         = CELL_HOLD;
        cmd.idx        = req.index;
        cmd.value      = req.value;
        cmd.rd_idx     = rd_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.action)
                        ACT_APPEND:
                        begin
                            if (full)
                                status = ST_FULL;
                            else
                            begin
                                cmd.op   = CELL_APPEND;
                                len_next = len_reg + 1'b1;
                            end
                        end
                        ACT_INSERT:
                        begin
                            if (full)
                                status = ST_FULL;
                            else if (idx_gt_len)
                                status = ST_RANGE;
                            else
                            begin
                                cmd.op   = CELL_INSERT;
                                len_next = len_reg + 1'b1;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (idx_ge_len)
                                status = ST_RANGE;
                            else
                            begin
                                cmd.op   = CELL_REMOVE;
                                len_next = len_reg - 1'b1;
                            end
                        end
                        ACT_TRUNCATE:
                        begin
                            if (idx_ge_len)
                                status = ST_RANGE;
                            else
                                len_next = LEN_W'(req.index);
                        end
                        ACT_READ:
                        begin
                            if (idx_ge_len)
                                status = ST_RANGE;
                        end
                        default:
                        begin
                            status = ST_DONE;
                        end
                    endcase

                    if (req.action == ACT_READ)
                    begin
                        rd_idx_next    = req.index;
                        rd_status_next = status;
                        wait_next      = WAIT_W'(LEVELS);
                        state_next     = S_READ;
                    end
                    else
                    begin
                        rsp_next.status     = status;
                        rsp_next.read_value = '0;
                        rsp_next.count      = COUNT_BITS'(len_next);
                        rsp_valid_next      = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                if (wait_reg != '0)
                    wait_next = wait_reg - 1'b1;
                else if (out_free)
                begin
                    rsp_next.status     = rd_status_reg;
                    rsp_next.read_value = VALUE_BITS'(tree_sum);
                    rsp_next.count      = COUNT_BITS'(len_reg);
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            capacity_reg  <= CAPACITY_RESET;
            wait_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            wait_reg      <= wait_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
                capacity_reg <= cfg_capacity;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rsp_reg       <= rsp_next;
        rd_idx_reg    <= rd_idx_next;
        rd_status_reg <= rd_status_next;
    end

    // Row of cells; each neighbor pair is wired both ways for shifting.
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [ENTRY_BITS-1:0] left_d;
        logic [ENTRY_BITS-1:0] right_d;

        if (k == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_data[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_right
            assign right_d = cell_data[k+1];
        end

        bal_cell #(
            .K          (k),
            .DEPTH      (DEPTH),
            .ENTRY_BITS (ENTRY_BITS)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .len        (len_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[k]),
            .leaf       (cell_leaf[k])
        );
    end

    // Read collection over the row.
    bal_read_tree #(
        .DEPTH      (DEPTH),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_read_tree (
        .clk  (clk),
        .leaf (cell_leaf),
        .sum  (tree_sum)
    );

    // Checks on the controller.
    `BAL_ASSERT_IMP(a_len_bound, clk, rst_n, 1'b1, len_reg <= LEN_W'(DEPTH), "length above depth")
    `BAL_ASSERT_NEXT(a_write_rsp, clk, rst_n, accept && (req.action != ACT_READ), rsp_valid_reg && (rsp_reg.count == COUNT_BITS'(len_reg)), "write response missing or count mismatch")
    `BAL_ASSERT_NEXT(a_read_done, clk, rst_n, (state_reg == S_READ) && (wait_reg == '0) && out_free, (state_reg == S_IDLE) && rsp_valid_reg, "read response not delivered")

endmodule

// ----- rtl/bal_cell.sv -----
// One cell of the list row: holds one entry and moves it to or from a neighbor.
// Depends on bal_pkg for the broadcast command struct.
module bal_cell #(
    parameter int K          = 0,
    parameter int DEPTH      = 64,
    parameter int ENTRY_BITS = 8
) (
    input  logic                         clk,
    input  bal_pkg::cell_cmd_t           cmd,
    input  logic [$clog2(DEPTH+1)-1:0]   len,
    input  logic [ENTRY_BITS-1:0]        left_data,
    input  logic [ENTRY_BITS-1:0]        right_data,
    output logic [ENTRY_BITS-1:0]        data,
    output logic [ENTRY_BITS-1:0]        leaf
);
    import bal_pkg::*;

    localparam int LEN_W = $clog2(DEPTH+1);
    localparam bit K_REACH = (K < (1 << INDEX_BITS));
    localparam logic [INDEX_BITS-1:0] K_IDX = INDEX_BITS'(K);
    localparam logic [LEN_W-1:0] K_LEN = LEN_W'(K);
    localparam logic [LEN_W-1:0] K_LEN1 = LEN_W'(K + 1);

    logic [ENTRY_BITS-1:0] data_reg;
    logic [ENTRY_BITS-1:0] data_next;
    logic [ENTRY_BITS-1:0] value_e;
    logic at_idx;
    logic above_idx;
    logic from_idx;
    logic at_len;
    logic within_len;
    logic before_last;
    logic rd_hit;

    // Position compares against the broadcast index and length.
    always_comb
    begin
        value_e     = ENTRY_BITS'(cmd.value);
        at_idx      = K_REACH && (K_IDX == cmd.idx);
        above_idx   = !K_REACH || (K_IDX > cmd.idx);
        from_idx    = !K_REACH || (K_IDX >= cmd.idx);
        at_len      = (K_LEN == len);
        within_len  = (K_LEN <= len);
        before_last = (K_LEN1 < len);
        rd_hit      = K_REACH && (K_IDX == cmd.rd_idx) && (K_LEN < len);
    end

    // Next entry value for the broadcast operation.
    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            CELL_APPEND:
            begin
                if (at_len)
                    data_next = value_e;
            end
            CELL_INSERT:
            begin
                if (at_idx)
                    data_next = value_e;
                else if (above_idx && within_len)
                    data_next = left_data;
            end
            CELL_REMOVE:
            begin
                if (from_idx && before_last)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Entry storage; undefined until written.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign leaf = rd_hit ? data_reg : '0;

endmodule

// ----- rtl/bal_read_tree.sv -----
// Registered radix-8 OR tree that collects the one selected entry of the row.
// Depends on bal_pkg for the level count.
module bal_read_tree #(
    parameter int DEPTH      = 64,
    parameter int ENTRY_BITS = 8
) (
    input  logic                  clk,
    input  logic [ENTRY_BITS-1:0] leaf [DEPTH],
    output logic [ENTRY_BITS-1:0] sum
);
    import bal_pkg::*;

    localparam int LEVELS = tree_levels(DEPTH);
    localparam int LEAVES = 1 << (3 * LEVELS);

    logic [ENTRY_BITS-1:0] pad       [LEAVES];
    logic [ENTRY_BITS-1:0] node      [LEVELS+1][LEAVES];
    logic [ENTRY_BITS-1:0] tree_reg  [LEVELS][LEAVES];
    logic [ENTRY_BITS-1:0] tree_next [LEVELS][LEAVES];

    // Pad the leaves up to a full power of eight.
    for (genvar j = 0; j < LEAVES; j++)
    begin : g_pad
        if (j < DEPTH)
        begin : g_leaf
            assign pad[j] = leaf[j];
        end
        else
        begin : g_zero
            assign pad[j] = '0;
        end
    end

    // Level zero is the padded leaves; level l is the register of stage l.
    always_comb
    begin
        node[0] = pad;
        for (int l = 1; l <= LEVELS; l++)
            node[l] = tree_reg[l-1];
    end

    // Each stage ORs groups of eight nodes of the level below.
    always_comb
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            for (int j = 0; j < LEAVES; j++)
                tree_next[l][j] = '0;
            for (int j = 0; j < LEAVES / 8; j++)
                for (int m = 0; m < 8; m++)
                    tree_next[l][j] = tree_next[l][j] | node[l][j*8 + m];
        end
    end

    always_ff @(posedge clk)
    begin
        tree_reg <= tree_next;
    end

    assign sum = node[LEVELS][0];

endmodule

// ----- sim/bounded_array_list_core_tb.sv -----
// Testbench for bounded_array_list_core: random and directed list actions are
// checked against an in-bench list predictor, under random idling on both sides.
// Depends on bal_pkg and the bounded_array_list_core RTL.
module bounded_array_list_core_tb;
    import bal_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEFAULT;
    localparam int SETTLE_TICKS = 8;
    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_PHASES   = 10;

    // Mix of actions used by a random phase.
    localparam int BIAS_MIXED  = 0;
    localparam int BIAS_GROW   = 1;
    localparam int BIAS_SHRINK = 2;

    // Contents and length of the list as the predictor sees it.
    typedef struct packed {
        logic [COUNT_BITS-1:0]                  len;
        logic [LIST_DEPTH-1:0][VALUE_BITS-1:0]  cells;
    } list_state_t;

    typedef struct packed {
        list_state_t st;
        rsp_item_t   rsp;
    } list_step_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     req_valid = 1'b0;
    logic                     req_ready;
    req_item_t                req = '0;
    logic                     rsp_valid;
    logic                     rsp_ready = 1'b0;
    rsp_item_t                rsp;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CAPACITY_BITS-1:0] cfg_capacity = CAPACITY_RESET;

    req_item_t                req_backlog[$];
    rsp_item_t                rsp_expected[$];
    list_state_t              list_now = '0;
    list_state_t              list_plan = '0;
    list_step_t               step_now;
    rsp_item_t                want;
    logic [CAPACITY_BITS-1:0] capacity_now = CAPACITY_RESET;
    logic                     quiet = 1'b0;
    int                       req_gap = 0;
    int                       rsp_stall = 0;
    int                       issued = 0;
    int                       checked = 0;
    int                       errors = 0;

    bounded_array_list_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_capacity (cfg_capacity)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Applies one action to a list and returns the new list and its response.
    function automatic list_step_t apply_action(list_state_t st,
                                                logic [CAPACITY_BITS-1:0] cap_reg,
                                                req_item_t it);
        list_step_t res;
        int limit;
        int len;
        int idx;
        int k;
        len = int'(st.len);
        idx = int'(it.index);
        limit = (int'(cap_reg) > LIST_DEPTH) ? LIST_DEPTH : int'(cap_reg);
        res.rsp = '0;
        res.rsp.status = ST_DONE;
        case (it.action)
            ACT_APPEND:
            begin
                if (len >= limit)
                    res.rsp.status = ST_FULL;
                else
                begin
                    st.cells[len] = it.value;
                    len++;
                end
            end
            ACT_INSERT:
            begin
                // Being full wins over a bad index.
                if (len >= limit)
                    res.rsp.status = ST_FULL;
                else if (idx > len)
                    res.rsp.status = ST_RANGE;
                else
                begin
                    for (k = len; k > idx; k--)
                        st.cells[k] = st.cells[k-1];
                    st.cells[idx] = it.value;
                    len++;
                end
            end
            ACT_REMOVE:
            begin
                if (idx >= len)
                    res.rsp.status = ST_RANGE;
                else
                begin
                    for (k = idx; k + 1 < len; k++)
                        st.cells[k] = st.cells[k+1];
                    len--;
                end
            end
            ACT_TRUNCATE:
            begin
                if (idx >= len)
                    res.rsp.status = ST_RANGE;
                else
                    len = idx;
            end
            ACT_READ:
            begin
                if (idx >= len)
                    res.rsp.status = ST_RANGE;
                else
                    res.rsp.read_value = st.cells[idx];
            end
            default:
            begin
                // Unused action codes leave the list alone.
            end
        endcase
        st.len = len[COUNT_BITS-1:0];
        res.rsp.count = st.len;
        res.st = st;
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Builds a random request, mostly with an index that fits the planned length.
    function automatic req_item_t make_item(int len, int bias);
        req_item_t it;
        int roll;
        int pick;
        int top;
        int idx;
        int a_end;
        int i_end;
        int r_end;
        int t_end;
        case (bias)
            BIAS_GROW:   begin a_end = 40; i_end = 70; r_end = 78; t_end = 80; end
            BIAS_SHRINK: begin a_end = 10; i_end = 20; r_end = 55; t_end = 65; end
            default:     begin a_end = 25; i_end = 45; r_end = 65; t_end = 72; end
        endcase
        roll = $urandom_range(0, 99);
        it.value = VALUE_BITS'($urandom_range(0, 255));
        if (roll >= 97)
            it.action = ACTION_BITS'($urandom_range(5, 7));
        else if (roll < a_end)
            it.action = ACT_APPEND;
        else if (roll < i_end)
            it.action = ACT_INSERT;
        else if (roll < r_end)
            it.action = ACT_REMOVE;
        else if (roll < t_end)
            it.action = ACT_TRUNCATE;
        else
            it.action = ACT_READ;

        pick = $urandom_range(0, 9);
        top = (it.action == ACT_INSERT) ? len : len - 1;
        if (top > LIST_DEPTH - 1)
            top = LIST_DEPTH - 1;
        if (it.action == ACT_TRUNCATE && pick < 7 && len > 0)
            idx = len - $urandom_range(1, (len < 4) ? len : 4);
        else if (pick < 7 && top >= 0)
            idx = $urandom_range(0, top);
        else if (pick < 9)
            idx = $urandom_range(0, LIST_DEPTH - 1);
        else
            idx = (len > LIST_DEPTH - 1) ? LIST_DEPTH - 1 : len;
        it.index = INDEX_BITS'(idx);
        return it;
    endfunction

    // Queues one request and advances the planning copy of the list.
    task automatic queue_item(input req_item_t it);
        list_step_t nxt;
        nxt = apply_action(list_plan, capacity_now, it);
        list_plan = nxt.st;
        req_backlog.push_back(it);
        issued++;
    endtask

    task automatic add_item(input logic [ACTION_BITS-1:0] action,
                            input int idx, input int val);
        req_item_t it;
        it.action = action;
        it.index = INDEX_BITS'(idx);
        it.value = VALUE_BITS'(val);
        queue_item(it);
    endtask

    // Waits until every queued request has its response, then lets the block settle.
    task automatic wait_idle();
        while (checked != issued)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // One transfer on the capacity port; only called while the block is idle.
    task automatic write_capacity(input logic [CAPACITY_BITS-1:0] cap);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_capacity <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        capacity_now = cap;
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
        end
    endtask

    // Request driver: presents queued requests and predicts each accepted transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            req_gap <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                step_now = apply_action(list_now, capacity_now, req);
                list_now = step_now.st;
                rsp_expected.push_back(step_now.rsp);
            end
            if (!req_valid || req_ready)
            begin
                if (req_gap > 0)
                begin
                    req_gap <= req_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (req_backlog.size() > 0)
                begin
                    req <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                    req_gap <= idle_len();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Response monitor: random back-pressure and in-order comparison.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_stall <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (rsp_expected.size() == 0)
                begin
                    errors++;
                    $display("%0t: response with no request waiting: expected none, actual %0d/%0h/%0d",
                             $time, rsp.status, rsp.read_value, rsp.count);
                end
                else
                begin
                    want = rsp_expected.pop_front();
                    checked++;
                    check_field("status", want.status, rsp.status);
                    check_field("read_value", want.read_value, rsp.read_value);
                    check_field("count", want.count, rsp.count);
                end
            end
            if (rsp_stall > 0)
            begin
                rsp_stall <= rsp_stall - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    rsp_stall <= idle_len();
            end
        end
    end

    // Stimulus: directed checks, then random phases at several capacities.
    initial
    begin
        int p;
        int n;
        int bias;
        logic [CAPACITY_BITS-1:0] cap_pick;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: every indexed action is out of range.
        add_item(ACT_READ, 0, 0);
        add_item(ACT_REMOVE, 0, 0);
        add_item(ACT_TRUNCATE, 0, 0);
        add_item(ACT_INSERT, 1, 8'h11);
        // Insert at the length appends.
        add_item(ACT_INSERT, 0, 8'hFF);
        add_item(ACT_APPEND, 0, 8'h00);
        add_item(ACT_APPEND, 63, 8'hA5);
        add_item(ACT_INSERT, 1, 8'h5A);
        add_item(ACT_READ, 0, 0);
        add_item(ACT_READ, 1, 0);
        add_item(ACT_READ, 2, 0);
        add_item(ACT_READ, 3, 0);
        add_item(ACT_READ, 4, 0);
        add_item(ACT_REMOVE, 1, 0);
        add_item(ACT_REMOVE, 2, 0);
        add_item(ACT_TRUNCATE, 1, 0);
        add_item(ACT_READ, 0, 0);
        add_item(3'd5, 63, 8'hFF);
        add_item(3'd6, 63, 8'hFF);
        add_item(3'd7, 63, 8'hFF);
        add_item(ACT_READ, 63, 0);
        add_item(ACT_TRUNCATE, 0, 0);
        wait_idle();

        // Small capacity: fill it, then a full insert with a bad index too.
        write_capacity(7'd2);
        add_item(ACT_APPEND, 0, 8'h01);
        add_item(ACT_APPEND, 0, 8'h02);
        add_item(ACT_APPEND, 0, 8'h03);
        add_item(ACT_INSERT, 5, 8'h04);
        add_item(ACT_REMOVE, 0, 0);
        add_item(ACT_INSERT, 3, 8'h05);
        wait_idle();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       begin cap_pick = 7'd64;  bias = BIAS_GROW;   end
                1:       begin cap_pick = 7'd127; bias = BIAS_MIXED;  end
                2:       begin cap_pick = 7'd3;   bias = BIAS_SHRINK; end
                3:       begin cap_pick = 7'd0;   bias = BIAS_MIXED;  end
                4:       begin cap_pick = 7'd1;   bias = BIAS_MIXED;  end
                5:       begin cap_pick = 7'd100; bias = BIAS_GROW;   end
                7:       begin cap_pick = 7'd64;  bias = BIAS_SHRINK; end
                8:       begin cap_pick = CAPACITY_BITS'($urandom_range(0, 127));
                               bias = BIAS_GROW; end
                9:       begin cap_pick = 7'd64;  bias = BIAS_MIXED;  end
                default: begin cap_pick = CAPACITY_BITS'($urandom_range(0, 127));
                               bias = BIAS_MIXED; end
            endcase
            write_capacity(cap_pick);
            quiet = (p % 4 == 3);
            for (n = 0; n < PHASE_ITEMS; n++)
                queue_item(make_item(int'(list_plan.len), bias));
            // The sender holds off here until every response is back.
            wait_idle();
        end

        if (errors == 0 && rsp_expected.size() == 0)
            $display("** bounded_array_list_core: PASSED **");
        else
            $display("** bounded_array_list_core: FAILED **");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2000000;
        $display("** bounded_array_list_core: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/bal_pkg.sv
rtl/bal_cell.sv
rtl/bal_read_tree.sv
rtl/bounded_array_list_core.sv
sim/bounded_array_list_core_tb.sv
